@@ hdl/yuv420_block_to_rgb24_core_assert.svh @@
// Assertion macros shared by the conversion core.
`ifndef YUV420_BLOCK_TO_RGB24_CORE_ASSERT_SVH
`define YUV420_BLOCK_TO_RGB24_CORE_ASSERT_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define Y420RGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("y420rgb assertion failed");

// Same check, but also evaluated while reset is applied.
`define Y420RGB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("y420rgb assertion failed");

`endif

@@ hdl/y420rgb_pkg.sv @@
package y420rgb_pkg;

  localparam int LumaGain   = 76309;
  localparam int HalfGain   = LumaGain / 2;
  localparam int RoundHalf  = 32768;
  localparam int LumaBlack  = 16;
  localparam int ChromaZero = 128;
  localparam int ChannelMax = 255;

  // floor(m / LumaGain) == (m * RecipGain) >> RecipShift for every m below 2**25.
  localparam int RecipShift = 42;
  localparam logic [25:0] RecipGain =
    26'(((64'd1 << RecipShift) + 64'(LumaGain) - 64'd1) / 64'(LumaGain));

  localparam logic [2:0] CoefSetReset = 3'd6;

  typedef struct packed {
    logic [17:0] crv;
    logic [17:0] cbu;
    logic [17:0] cgu;
    logic [17:0] cgv;
  } coef_row_t;

  localparam coef_row_t CoefTable [8] = '{
    '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903},
    '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903},
    '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
    '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
    '{crv: 18'd104448, cbu: 18'd132798, cgu: 18'd24759, cgv: 18'd53109},
    '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
    '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
    '{crv: 18'd117579, cbu: 18'd136230, cgu: 18'd16907, cgv: 18'd35559}
  };

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef struct packed {
    logic signed [9:0] r;
    logic signed [9:0] g;
    logic signed [9:0] b;
  } offsets_t;

endpackage

@@ hdl/y420rgb_offset.sv @@
module y420rgb_offset (
  input  logic                   clk,
  input  y420rgb_pkg::stage_en_t en,
  input  logic [17:0]            coef,
  input  logic [7:0]             chroma,
  input  logic                   invert,
  output logic signed [8:0]      offset
);
  import y420rgb_pkg::*;

  logic [7:0]  chroma_mag;
  logic        chroma_neg;
  logic [24:0] prod_full;
  logic [24:0] prod_mag;
  logic        prod_neg;
  logic [24:0] rounded;
  logic [50:0] scaled;
  logic [7:0]  quot;

  always_comb begin
    if (chroma[7]) begin
      chroma_mag = {1'b0, chroma[6:0]};
      chroma_neg = 1'b0;
    end else begin
      chroma_mag = 8'(ChromaZero) - chroma;
      chroma_neg = 1'b1;
    end
  end

  assign prod_full = 25'(coef) * 25'(chroma_mag);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_mag <= prod_full;
      prod_neg <= chroma_neg ^ invert;
    end
  end

  // Rounding is done on the magnitude, so halves round away from zero.
  assign rounded = prod_mag + 25'(HalfGain);
  assign scaled  = 51'(rounded) * 51'(RecipGain);
  assign quot    = scaled[RecipShift +: 8];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      offset <= prod_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
  end

endmodule

@@ hdl/y420rgb_lane.sv @@
module y420rgb_lane (
  input  logic                  clk,
  input  logic                  en,
  input  logic [7:0]            luma,
  input  y420rgb_pkg::offsets_t off,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue
);
  import y420rgb_pkg::*;

  function automatic logic [7:0] convert(logic [7:0] y, logic signed [9:0] o);
    logic signed [10:0] t;
    logic signed [27:0] v;
    begin
      t = $signed({3'b000, y}) + 11'(o) - 11'(LumaBlack);
      v = 28'(t) * 28'(LumaGain) + 28'(RoundHalf);
      if (v[27]) begin
        convert = 8'd0;
      end else if (v[27:16] > 12'(ChannelMax)) begin
        convert = 8'(ChannelMax);
      end else begin
        convert = v[23:16];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= convert(luma, off.r);
      green <= convert(luma, off.g);
      blue  <= convert(luma, off.b);
    end
  end

endmodule

@@ hdl/yuv420_block_to_rgb24_core.sv @@
// 4:2:0 to RGB24 converter for one 2x2 block per item.
// Input channel: item_valid / item_ready with four luma bytes and the shared
// chroma_blue (U) and chroma_red (V) bytes. Output channel: result_valid /
// result_ready with the red, green and blue bytes of the four pixels.
// cfg_we writes cfg_data into the coefficient set register in the same edge;
// write it only while the block is idle.
// Throughput is one item per clock while the receiver keeps result_ready
// high: the pipeline has four stages (chroma products, rounded offsets,
// pixel lanes, output register), and result_valid is the output stage valid.
// Every stage carries a valid bit and moves as soon as the one after it is
// empty or moving, so a stalled receiver first fills the bubbles and only then
// drops item_ready; no item is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets the coefficient set
// to row 6.
module yuv420_block_to_rgb24_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] luma_top_left,
  input  logic [7:0] luma_top_right,
  input  logic [7:0] luma_bottom_left,
  input  logic [7:0] luma_bottom_right,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] red_top_left,
  output logic [7:0] green_top_left,
  output logic [7:0] blue_top_left,
  output logic [7:0] red_top_right,
  output logic [7:0] green_top_right,
  output logic [7:0] blue_top_right,
  output logic [7:0] red_bottom_left,
  output logic [7:0] green_bottom_left,
  output logic [7:0] blue_bottom_left,
  output logic [7:0] red_bottom_right,
  output logic [7:0] green_bottom_right,
  output logic [7:0] blue_bottom_right
);
  import y420rgb_pkg::*;

  `include "yuv420_block_to_rgb24_core_assert.svh"

  logic [2:0] coefficient_set;
  coef_row_t  row;

  logic v1, v2, v3, v4;
  logic a1, a2, a3, a4;
  stage_en_t en;

  logic [7:0] luma_in [4];
  logic [7:0] luma1   [4];
  logic [7:0] luma2   [4];

  logic signed [8:0] off_r, off_gu, off_gv, off_b;
  offsets_t offs;

  logic [7:0] lane_r [4];
  logic [7:0] lane_g [4];
  logic [7:0] lane_b [4];
  logic [7:0] out_r  [4];
  logic [7:0] out_g  [4];
  logic [7:0] out_b  [4];

  // Each stage advances when the one after it is empty or advancing.
  assign a4 = !v4 || result_ready;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign item_ready   = a1;
  assign result_valid = v4;
  assign en.s1 = a1;
  assign en.s2 = a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient_set <= CoefSetReset;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (cfg_we) begin
        coefficient_set <= cfg_data;
      end
      if (a1) v1 <= item_valid;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
    end
  end

  assign row = CoefTable[coefficient_set];

  assign luma_in[0] = luma_top_left;
  assign luma_in[1] = luma_top_right;
  assign luma_in[2] = luma_bottom_left;
  assign luma_in[3] = luma_bottom_right;

  always_ff @(posedge clk) begin
    if (a1) luma1 <= luma_in;
    if (a2) luma2 <= luma1;
  end

  y420rgb_offset u_off_r (
    .clk(clk), .en(en), .coef(row.crv), .chroma(chroma_red), .invert(1'b0),
    .offset(off_r)
  );
  y420rgb_offset u_off_gu (
    .clk(clk), .en(en), .coef(row.cgu), .chroma(chroma_blue), .invert(1'b1),
    .offset(off_gu)
  );
  y420rgb_offset u_off_gv (
    .clk(clk), .en(en), .coef(row.cgv), .chroma(chroma_red), .invert(1'b1),
    .offset(off_gv)
  );
  y420rgb_offset u_off_b (
    .clk(clk), .en(en), .coef(row.cbu), .chroma(chroma_blue), .invert(1'b0),
    .offset(off_b)
  );

  // Green uses the sum of its two separately rounded offsets.
  assign offs.r = 10'(off_r);
  assign offs.g = 10'(off_gu) + 10'(off_gv);
  assign offs.b = 10'(off_b);

  for (genvar i = 0; i < 4; i++) begin : g_lane
    y420rgb_lane u_lane (
      .clk(clk), .en(a3), .luma(luma2[i]), .off(offs),
      .red(lane_r[i]), .green(lane_g[i]), .blue(lane_b[i])
    );
  end

  // Output stage gathers the four lanes into one result item.
  always_ff @(posedge clk) begin
    if (a4) begin
      out_r <= lane_r;
      out_g <= lane_g;
      out_b <= lane_b;
    end
  end

  assign red_top_left       = out_r[0];
  assign green_top_left     = out_g[0];
  assign blue_top_left      = out_b[0];
  assign red_top_right      = out_r[1];
  assign green_top_right    = out_g[1];
  assign blue_top_right     = out_b[1];
  assign red_bottom_left    = out_r[2];
  assign green_bottom_left  = out_g[2];
  assign blue_bottom_left   = out_b[2];
  assign red_bottom_right   = out_r[3];
  assign green_bottom_right = out_g[3];
  assign blue_bottom_right  = out_b[3];

  `Y420RGB_ASSERT_NEXT(a_accept_fills_s1, item_valid && item_ready, v1)
  `Y420RGB_ASSERT_NEXT(a_s3_reaches_out, v3 && a4, result_valid)
  `Y420RGB_ASSERT_NEXT(a_stall_keeps_s3, v3 && !a4, v3 && v4)
  `Y420RGB_ASSERT_NEXT_ALWAYS(a_reset_coef, rst, coefficient_set == CoefSetReset)

endmodule
